// ===== sv/ckm_pkg.sv =====
// ----------------------------------------------------------------------------
// ckm_pkg: shared types and constants of the canonical k-mer minimizer
// Field widths, register indexes, multiplier steps and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ckm_pkg;

  localparam int BASE_W   = 2;
  localparam int HASH_W   = 62;
  localparam int POS_W    = 32;
  localparam int MULT_W   = 64;
  localparam int K_W      = 5;
  localparam int WIN_W    = 7;
  localparam int CNT_W    = 64;
  localparam int IDX_W    = 2;
  localparam int BSEEN_W  = 32;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_MULT = 2'd0,
    REG_KLEN = 2'd1,
    REG_WSZ  = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  // Partial product sequence of the 64-bit hash multiply
  typedef enum logic [1:0] {
    MS_LL  = 2'd0,
    MS_LH  = 2'd1,
    MS_HL  = 2'd2,
    MS_ADD = 2'd3
  } mul_step_t;

  typedef struct packed {
    logic      load;
    logic      mul_en;
    mul_step_t mul_step;
    logic      mul_rev;
    logic      cap_fwd;
    logic      write;
    logic      scan_init;
    logic      scan_full;
    logic      scan_cmp;
    logic      emit;
    logic      clear;
  } ckm_cmd_t;

  typedef struct packed {
    logic have_kmer;
    logic full;
    logic partial;
    logic last;
    logic scan_last;
    logic emit_ok;
    logic out_free;
  } ckm_stat_t;

endpackage

`default_nettype wire

// ===== sv/ckm_if.sv =====
// ----------------------------------------------------------------------------
// ckm_if: channel interfaces of the canonical k-mer minimizer
// Base input, minimizer output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface ckm_base_if;
  logic                         valid;
  logic                         ready;
  logic [ckm_pkg::BASE_W-1:0]   base;
  logic                         last_base;
  modport source (output valid, base, last_base, input ready);
  modport sink   (input valid, base, last_base, output ready);
endinterface

interface ckm_min_if;
  logic                         valid;
  logic                         ready;
  logic [ckm_pkg::HASH_W-1:0]   min_hash;
  logic [ckm_pkg::POS_W-1:0]    kmer_position;
  modport source (output valid, min_hash, kmer_position, input ready);
  modport sink   (input valid, min_hash, kmer_position, output ready);
endinterface

interface ckm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ckm_pkg::IDX_W-1:0]    index;
  logic [ckm_pkg::MULT_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/ckm_ram.sv =====
// ----------------------------------------------------------------------------
// ckm_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/ckm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ckm_ctrl: sequencer of the canonical k-mer minimizer
// Steps one base through hashing, ring write, window scan and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ckm_pkg::ckm_stat_t stat,
  output ckm_pkg::ckm_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_KCHK, S_MUL, S_WRITE, S_CHECK, S_CHKEND,
    S_SCAN_RD, S_SCAN_CMP, S_DECIDE, S_EMIT, S_FINISH
  } state_t;

  state_t              state;
  logic [1:0]          mstep;
  logic                mrev;
  logic                scan_full;

  assign in_ready = (state == S_IDLE);

  // Decode commands from the current state
  always_comb begin
    cmd           = '0;
    cmd.mul_step  = ckm_pkg::mul_step_t'(mstep);
    cmd.mul_rev   = mrev;
    cmd.scan_full = scan_full;
    unique case (state)
      S_IDLE:     cmd.load = in_valid;
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.cap_fwd = mrev && (mstep == 2'(ckm_pkg::MS_LL));
      end
      S_WRITE:    cmd.write = 1'b1;
      S_CHECK: begin
        cmd.scan_init = stat.full;
        cmd.scan_full = 1'b1;
      end
      S_CHKEND: begin
        cmd.scan_init = stat.last && stat.partial;
        cmd.scan_full = 1'b0;
      end
      S_SCAN_CMP: cmd.scan_cmp = 1'b1;
      S_EMIT:     cmd.emit = stat.out_free;
      S_FINISH:   cmd.clear = stat.last;
      default:    cmd.load = 1'b0;
    endcase
  end

  // Hold state and step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mstep     <= '0;
      mrev      <= 1'b0;
      scan_full <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_KCHK;
        S_KCHK: begin
          mstep <= '0;
          mrev  <= 1'b0;
          state <= stat.have_kmer ? S_MUL : S_CHKEND;
        end
        S_MUL: begin
          mstep <= mstep + 2'd1;
          if (mstep == 2'(ckm_pkg::MS_ADD)) begin
            mrev <= 1'b1;
            if (mrev) state <= S_WRITE;
          end
        end
        S_WRITE: state <= S_CHECK;
        S_CHECK: begin
          if (stat.full) begin
            scan_full <= 1'b1;
            state     <= S_SCAN_RD;
          end else begin
            state <= S_CHKEND;
          end
        end
        S_CHKEND: begin
          scan_full <= 1'b0;
          state     <= (stat.last && stat.partial) ? S_SCAN_RD : S_FINISH;
        end
        S_SCAN_RD:  state <= S_SCAN_CMP;
        S_SCAN_CMP: state <= stat.scan_last ? S_DECIDE : S_SCAN_RD;
        S_DECIDE:   state <= (scan_full || stat.emit_ok) ? S_EMIT : S_FINISH;
        S_EMIT:     if (stat.out_free) state <= S_FINISH;
        S_FINISH:   state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/ckm_dp.sv =====
// ----------------------------------------------------------------------------
// ckm_dp: datapath of the canonical k-mer minimizer
// K-mer shift registers, shared 32x32 hash multiplier, hash ring, window
// scan, output register and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_dp #(
  parameter int MAX_WINDOW    = 64,
  parameter int POSITION_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  ckm_base_if.sink               bases,
  ckm_min_if.source              minimizers,
  ckm_cfg_if.sink                cfg,
  input  wire ckm_pkg::ckm_cmd_t cmd,
  output ckm_pkg::ckm_stat_t     stat,
  input  wire logic              in_ready
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int RW = $clog2(MAX_WINDOW + 1);
  localparam logic [ckm_pkg::CNT_W-1:0] POS_SAT =
    (ckm_pkg::CNT_W'(1) << POSITION_BITS) - ckm_pkg::CNT_W'(1);

  // Configuration
  logic [ckm_pkg::MULT_W-1:0] mult;
  logic [ckm_pkg::K_W-1:0]    klen;
  logic [ckm_pkg::WIN_W-1:0]  wsz;

  // Sequence state
  logic [ckm_pkg::HASH_W-1:0]  fwd, rev;
  logic [ckm_pkg::BSEEN_W-1:0] seen;
  logic [ckm_pkg::CNT_W-1:0]   kcount, win_start;
  logic [AW-1:0]               wr_ptr, win_idx;
  logic [ckm_pkg::HASH_W-1:0]  prev_h;
  logic                        first_emitted;
  logic                        last;

  // Hash unit
  logic [ckm_pkg::MULT_W-1:0]  prod, acc;
  logic [ckm_pkg::HASH_W-1:0]  hf;

  // Scan
  logic [ckm_pkg::CNT_W-1:0]   spos, best_pos;
  logic [AW-1:0]               sidx, best_idx;
  logic [RW-1:0]               srem;
  logic                        sfirst;
  logic [ckm_pkg::HASH_W-1:0]  best_h, rdata;

  logic                        out_valid;
  logic [ckm_pkg::HASH_W-1:0]  out_hash;
  logic [ckm_pkg::POS_W-1:0]   out_pos;

  logic [ckm_pkg::K_W-1:0]     k_eff;
  logic [6:0]                  two_k, sh;
  logic [ckm_pkg::HASH_W-1:0]  kmask, fwd_next, rev_next, hcur, canon;
  logic [8:0]                  w_eff;
  logic [ckm_pkg::CNT_W-1:0]   span;
  logic [ckm_pkg::MULT_W-1:0]  xsel;
  logic [31:0]                 ma, mb;
  logic [AW-1:0]               sidx_next, best_idx_next;
  logic [ckm_pkg::CNT_W-1:0]   pos_sat;

  // Effective k, window and masks
  always_comb begin
    k_eff = (klen == '0) ? ckm_pkg::K_W'(1) : klen;
    two_k = {1'b0, k_eff, 1'b0};
    sh    = 7'd64 - two_k;
    kmask = ckm_pkg::HASH_W'((ckm_pkg::MULT_W'(1) << two_k) - ckm_pkg::MULT_W'(1));
    if (wsz == '0) begin
      w_eff = 9'd1;
    end else if ({2'b0, wsz} > 9'(MAX_WINDOW)) begin
      w_eff = 9'(MAX_WINDOW);
    end else begin
      w_eff = {2'b0, wsz};
    end
    fwd_next = ((fwd << 2) | ckm_pkg::HASH_W'(bases.base)) & kmask;
    rev_next = ((rev >> 2) |
                (ckm_pkg::HASH_W'(2'd3 - bases.base) << (two_k - 7'd2))) & kmask;
    span     = kcount - win_start;
    hcur     = ckm_pkg::HASH_W'(acc >> sh);
    canon    = (hf < hcur) ? hf : hcur;
  end

  // Operand selection of the shared multiplier
  always_comb begin
    xsel = cmd.mul_rev ? {2'b0, rev} : {2'b0, fwd};
    ma   = xsel[31:0];
    mb   = mult[31:0];
    case (cmd.mul_step)
      ckm_pkg::MS_LH: mb = mult[63:32];
      ckm_pkg::MS_HL: ma = xsel[63:32];
      default:        ma = xsel[31:0];
    endcase
  end

  assign sidx_next     = (sidx == AW'(MAX_WINDOW - 1)) ? '0 : sidx + AW'(1);
  assign best_idx_next = (best_idx == AW'(MAX_WINDOW - 1)) ? '0 : best_idx + AW'(1);
  assign pos_sat       = (best_pos > POS_SAT) ? POS_SAT : best_pos;

  ckm_ram #(.WIDTH(ckm_pkg::HASH_W), .DEPTH(MAX_WINDOW)) u_ring (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (wr_ptr),
    .wdata (canon),
    .raddr (sidx),
    .rdata (rdata)
  );

  assign cfg.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mult <= ckm_pkg::MULT_W'(1);
      klen <= ckm_pkg::K_W'(16);
      wsz  <= ckm_pkg::WIN_W'(32);
    end else if (cfg.valid) begin
      unique case (ckm_pkg::reg_idx_t'(cfg.index))
        ckm_pkg::REG_MULT: mult <= cfg.data;
        ckm_pkg::REG_KLEN: klen <= cfg.data[ckm_pkg::K_W-1:0];
        ckm_pkg::REG_WSZ:  wsz  <= cfg.data[ckm_pkg::WIN_W-1:0];
        default:           mult <= mult;
      endcase
    end
  end

  // Multiply in partial products and accumulate the low 64 bits
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= ckm_pkg::MULT_W'(ma) * ckm_pkg::MULT_W'(mb);
      case (cmd.mul_step)
        ckm_pkg::MS_LH:  acc <= prod;
        ckm_pkg::MS_HL,
        ckm_pkg::MS_ADD: acc <= acc + {prod[31:0], 32'b0};
        default:         acc <= acc;
      endcase
    end
    if (cmd.cap_fwd) hf <= hcur;
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fwd           <= '0;
      rev           <= '0;
      seen          <= '0;
      kcount        <= '0;
      win_start     <= '0;
      wr_ptr        <= '0;
      win_idx       <= '0;
      prev_h        <= '1;
      first_emitted <= 1'b0;
    end else begin
      if (cmd.load) begin
        fwd  <= fwd_next;
        rev  <= rev_next;
        if (seen != '1) seen <= seen + 1'b1;
      end
      if (cmd.write) begin
        kcount <= kcount + 1'b1;
        wr_ptr <= (wr_ptr == AW'(MAX_WINDOW - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (cmd.emit) begin
        prev_h        <= best_h;
        first_emitted <= 1'b1;
        win_start     <= best_pos + 1'b1;
        win_idx       <= best_idx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) last <= bases.last_base;
  end

  // Walk the window, earliest entry wins on ties
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      spos   <= win_start;
      sidx   <= win_idx;
      srem   <= cmd.scan_full ? RW'(w_eff) : RW'(span);
      sfirst <= 1'b1;
    end else if (cmd.scan_cmp) begin
      if (sfirst || rdata < best_h) begin
        best_h   <= rdata;
        best_pos <= spos;
        best_idx <= sidx;
      end
      sfirst <= 1'b0;
      spos   <= spos + 1'b1;
      sidx   <= sidx_next;
      srem   <= srem - RW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (minimizers.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_hash <= best_h;
      out_pos  <= pos_sat[ckm_pkg::POS_W-1:0];
    end
  end

  assign bases.ready              = in_ready;
  assign minimizers.valid         = out_valid;
  assign minimizers.min_hash      = out_hash;
  assign minimizers.kmer_position = out_pos;

  // Status to the controller
  always_comb begin
    stat.have_kmer = seen >= ckm_pkg::BSEEN_W'(k_eff);
    stat.full      = span >= ckm_pkg::CNT_W'(w_eff);
    stat.partial   = kcount > win_start;
    stat.last      = last;
    stat.scan_last = (srem == RW'(1));
    stat.emit_ok   = !first_emitted || (best_h < prev_h);
    stat.out_free  = !out_valid || minimizers.ready;
  end

endmodule

`default_nettype wire

// ===== sv/canonical_kmer_minimizer_top.sv =====
// Flow: a taken base is hashed and written to the ring, then the window is
// scanned entry by entry (ring read, then compare), and the minimizer is
// written to the output register; emission waits while that register is full.
// Throughput: one base in flight; the next is taken once the current base is
// finished, set by the shared 32x32 multiplier (8 steps) and the window scan.
// Reset: rst is synchronous; restores register defaults, clears sequence state.
`default_nettype none

module canonical_kmer_minimizer_top #(
  parameter int MAX_WINDOW    = 64,
  parameter int POSITION_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ckm_base_if.sink   bases,
  ckm_min_if.source  minimizers,
  ckm_cfg_if.sink    cfg
);

  ckm_pkg::ckm_cmd_t  cmd;
  ckm_pkg::ckm_stat_t stat;
  logic               in_ready;

  ckm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bases.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ckm_dp #(
    .MAX_WINDOW    (MAX_WINDOW),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .bases      (bases),
    .minimizers (minimizers),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .in_ready   (in_ready)
  );

endmodule

`default_nettype wire

// ===== sv/ckm_checker.sv =====
// ----------------------------------------------------------------------------
// ckm_checker: port level checks of the canonical k-mer minimizer
// Watches the base and minimizer channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [ckm_pkg::HASH_W-1:0] out_hash
);

  // A stalled result holds its hash
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_hash))
    else $error("minimizer changed while stalled");

  // Busy after taking a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous base in flight");

  // A new result only appears while a base is still being finished
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready)
    else $error("result appeared while idle");

  // Nothing pending straight after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind canonical_kmer_minimizer_top ckm_checker u_ckm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bases.valid),
  .in_ready  (bases.ready),
  .out_valid (minimizers.valid),
  .out_ready (minimizers.ready),
  .out_hash  (minimizers.min_hash)
);

`default_nettype wire

// ===== dv/canonical_kmer_minimizer_top_test.sv =====
// ----------------------------------------------------------------------------
// canonical_kmer_minimizer_top_test: regression of the k-mer minimizer
// Feeds base sequences under many register settings, predicts each minimizer
// in step with accepted bases, and checks results in order against it.
// Both channels idle at random, and one long output stall fills the block.
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_kmer_minimizer_top_test;

  typedef struct packed {
    logic [ckm_pkg::BASE_W-1:0] base;
    logic                       last_base;
  } base_req_t;

  typedef struct packed {
    logic [ckm_pkg::HASH_W-1:0] min_hash;
    logic [ckm_pkg::POS_W-1:0]  kmer_position;
  } mini_t;

  logic clk;
  logic rst;

  ckm_base_if bases ();
  ckm_min_if  minimizers ();
  ckm_cfg_if  cfg ();

  canonical_kmer_minimizer_top u_top (
    .clk        (clk),
    .rst        (rst),
    .bases      (bases.sink),
    .minimizers (minimizers.source),
    .cfg        (cfg.sink)
  );

  base_req_t base_queue[$];
  mini_t     minimizer_queue[$];
  int        errors;
  int        cycles;
  bit        calm;
  bit        in_acc;
  int        long_hold;
  int        src_gap;
  int        snk_gap;

  // predicted registers and sequence state
  logic [63:0] p_mult;
  logic [4:0]  p_klen;
  logic [6:0]  p_wsz;
  logic [63:0] p_fwd, p_rev, p_seen, p_count, p_start, p_prev_pos;
  logic [ckm_pkg::HASH_W-1:0] p_prev_hash;
  bit          p_first;
  logic [ckm_pkg::HASH_W-1:0] p_ring [64];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic clear_seq();
    p_fwd = '0; p_rev = '0; p_seen = '0; p_count = '0; p_start = '0;
    p_prev_pos = '0; p_prev_hash = '1; p_first = 0;
  endtask

  // minimum over k-mer positions [from, to), earliest wins on ties
  task automatic window_min(input logic [63:0] from, input logic [63:0] to,
                            output logic [ckm_pkg::HASH_W-1:0] h,
                            output logic [63:0] p);
    logic [63:0] i;
    if (to - from > 64) from = to - 64;
    h = p_ring[from[5:0]];
    p = from;
    for (i = from + 1; i < to; i++) begin
      if (p_ring[i[5:0]] < h) begin
        h = p_ring[i[5:0]];
        p = i;
      end
    end
  endtask

  task automatic record_min(input logic [ckm_pkg::HASH_W-1:0] h,
                            input logic [63:0] p);
    mini_t m;
    m.min_hash = h;
    m.kmer_position = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    minimizer_queue.push_back(m);
    p_prev_hash = h;
    p_prev_pos = p;
    p_first = 1;
    p_start = p + 1;
  endtask

  // advance the predicted state by one accepted base
  task automatic predict_base(input base_req_t r);
    logic [63:0] k, w, mask, hf, hr, prod, p;
    logic [ckm_pkg::HASH_W-1:0] h;
    bit done;
    done = 0;
    k = (p_klen == 0) ? 1 : p_klen;
    w = (p_wsz == 0) ? 1 : ((p_wsz > 64) ? 64 : p_wsz);
    mask = (64'd1 << (2 * k)) - 1;
    p_fwd = ((p_fwd << 2) & mask) | r.base;
    p_rev = ((p_rev >> 2) | ((64'd3 - r.base) << (2 * k - 2))) & mask;
    if (p_seen < 64'hFFFF_FFFF) p_seen++;
    if (p_seen >= k) begin
      prod = p_fwd * p_mult;
      hf = prod >> (64 - 2 * k);
      prod = p_rev * p_mult;
      hr = prod >> (64 - 2 * k);
      p_ring[p_count[5:0]] = (hf < hr) ? hf[ckm_pkg::HASH_W-1:0] : hr[ckm_pkg::HASH_W-1:0];
      p_count++;
      if (p_count - p_start >= w) begin
        window_min(p_start, p_start + w, h, p);
        record_min(h, p);
        done = 1;
      end
    end
    if (r.last_base) begin
      if (!done && p_count > p_start) begin
        window_min(p_start, p_count, h, p);
        if (!p_first || h < p_prev_hash) record_min(h, p);
      end
      clear_seq();
    end
  endtask

  // sample both channels, check results, then predict accepted bases
  always @(posedge clk) begin
    mini_t m;
    cycles <= cycles + 1;
    in_acc <= bases.valid && bases.ready;
    if (cycles > 3000000) begin
      $display("canonical_kmer_minimizer_top regression: fail");
      $finish;
    end
    if (rst) begin
      p_mult = 64'd1; p_klen = 5'd16; p_wsz = 7'd32;
      clear_seq();
    end else begin
      if (minimizers.valid && minimizers.ready) begin
        if (minimizer_queue.size() == 0) begin
          $error("unexpected result hash %h position %h",
                 minimizers.min_hash, minimizers.kmer_position);
          errors++;
        end else begin
          m = minimizer_queue.pop_front();
          if (m.min_hash !== minimizers.min_hash) begin
            $error("min_hash expected %h actual %h", m.min_hash, minimizers.min_hash);
            errors++;
          end
          if (m.kmer_position !== minimizers.kmer_position) begin
            $error("kmer_position expected %h actual %h",
                   m.kmer_position, minimizers.kmer_position);
            errors++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (ckm_pkg::reg_idx_t'(cfg.index))
          ckm_pkg::REG_MULT: p_mult = cfg.data;
          ckm_pkg::REG_KLEN: p_klen = cfg.data[4:0];
          ckm_pkg::REG_WSZ:  p_wsz  = cfg.data[6:0];
          default: ;
        endcase
      end
      if (bases.valid && bases.ready)
        predict_base('{base: bases.base, last_base: bases.last_base});
    end
  end

  // base driver: hold a request until taken, gaps in bursts
  always @(negedge clk) begin
    base_req_t r;
    if (rst) begin
      bases.valid <= 1'b0;
    end else if (bases.valid && !in_acc) begin
      // hold
    end else if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      bases.valid <= 1'b0;
    end else if (base_queue.size() != 0) begin
      r = base_queue.pop_front();
      bases.valid <= 1'b1;
      bases.base <= r.base;
      bases.last_base <= r.last_base;
      if (!calm && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 18);
    end else begin
      bases.valid <= 1'b0;
    end
  end

  // result sink: long hold-off when asked, otherwise random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      minimizers.ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      minimizers.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      minimizers.ready <= 1'b0;
    end else begin
      minimizers.ready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) snk_gap <= $urandom_range(1, 18);
    end
  end

  task automatic write_reg(input ckm_pkg::reg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // let all bases drain and every expected result arrive
  task automatic wait_idle();
    while (base_queue.size() != 0 || bases.valid || minimizer_queue.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic add_seq(input int len);
    base_req_t r;
    for (int i = 0; i < len; i++) begin
      r.base = 2'($urandom_range(0, 3));
      r.last_base = (i == len - 1);
      base_queue.push_back(r);
    end
  endtask

  task automatic add_fixed(input logic [1:0] b, input bit last);
    base_req_t r;
    r.base = b;
    r.last_base = last;
    base_queue.push_back(r);
  endtask

  initial begin
    int k, w, len;
    errors = 0; cycles = 0; calm = 0; long_hold = 0; src_gap = 0; snk_gap = 0;
    bases.valid = 1'b0; bases.base = '0; bases.last_base = 1'b0;
    minimizers.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = ckm_pkg::REG_MULT; cfg.data = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: a sequence too short to fill a window, emitted as a partial tail
    add_seq(20);
    wait_idle();

    // zero length and zero window act as one; even multiplier; single-base and two-base sequences
    write_reg(ckm_pkg::REG_KLEN, 64'd0);
    write_reg(ckm_pkg::REG_WSZ, 64'd0);
    write_reg(ckm_pkg::REG_MULT, 64'h0000_0000_0000_0002);
    add_fixed(2'd0, 1'b1);
    add_fixed(2'd3, 1'b1);
    add_fixed(2'd1, 1'b0);
    add_fixed(2'd2, 1'b1);
    wait_idle();

    // longest k-mer, oversized window, all-ones multiplier; ignored index
    write_reg(ckm_pkg::REG_KLEN, 64'd31);
    write_reg(ckm_pkg::REG_WSZ, 64'd127);
    write_reg(ckm_pkg::REG_MULT, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(ckm_pkg::REG_NONE, 64'h1234);
    add_seq(10);
    for (int i = 0; i < 4; i++) add_fixed(2'd3, i == 3);
    wait_idle();

    // random settings, mostly well-formed sequences of useful length
    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 4))
        0: k = 1;
        1: k = 31;
        default: k = $urandom_range(1, 31);
      endcase
      case ($urandom_range(0, 5))
        0: w = 1;
        1: w = 64;
        2: w = 127;
        default: w = $urandom_range(1, 12);
      endcase
      write_reg(ckm_pkg::REG_MULT, {$urandom, $urandom} | 64'd1);
      write_reg(ckm_pkg::REG_KLEN, 64'(k));
      write_reg(ckm_pkg::REG_WSZ, 64'(w));
      if (ph == 13) calm = 1;
      while (base_queue.size() < 110) begin
        if ($urandom_range(0, 5) == 0) len = $urandom_range(1, k + 1);
        else len = k + $urandom_range(0, (w > 64 ? 64 : w) * 2 + 4);
        if (len > 120) len = $urandom_range(k, 120);
        add_seq(len);
      end
      if (ph == 4) begin
        long_hold = 3000;
        while (long_hold > 0) @(posedge clk);
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("canonical_kmer_minimizer_top regression: pass");
    end else begin
      $display("canonical_kmer_minimizer_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/ckm_pkg.sv
sv/ckm_if.sv
sv/ckm_ram.sv
sv/ckm_ctrl.sv
sv/ckm_dp.sv
sv/canonical_kmer_minimizer_top.sv
sv/ckm_checker.sv
dv/canonical_kmer_minimizer_top_test.sv
